// ===== hdl/ftws_pkg.sv =====
package ftws_pkg;

    // Window geometry
    localparam int WINDOW_DEPTH = 32;
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

    // Field widths
    localparam int TICK_W   = 32;
    localparam int RATE_W   = 24;
    localparam int FILLED_W = 6;
    localparam int FRAC_W   = 8;

    // Datapath widths: running sum and shared divider dividend
    localparam int SUM_W   = TICK_W + FILL_W;
    localparam int DIV_W   = (SUM_W > TICK_W + FRAC_W) ? SUM_W : TICK_W + FRAC_W;
    localparam int STEP_W  = $clog2(DIV_W + 1);

    localparam logic [RATE_W-1:0] RATE_MAX  = {RATE_W{1'b1}};
    localparam logic [TICK_W-1:0] TPS_RESET = 32'd1000000000;

    // Opcodes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [TICK_W-1:0] interframe_ticks;
        logic [TICK_W-1:0] frame_ticks;
    } in_t;

    typedef struct packed {
        logic [TICK_W-1:0]   interframe_avg;
        logic [TICK_W-1:0]   interframe_min;
        logic [TICK_W-1:0]   interframe_max;
        logic [TICK_W-1:0]   busy_avg;
        logic [TICK_W-1:0]   busy_min;
        logic [TICK_W-1:0]   busy_max;
        logic [RATE_W-1:0]   rate_q8;
        logic [FILLED_W-1:0] filled;
    } out_t;

endpackage

// ===== hdl/frame_time_window_stats.sv =====
// Sliding-window frame timing statistics. Each input transaction either adds an
// (interframe, frame) tick pair to a ring of WINDOW_DEPTH slots or clears the
// window; every input transaction yields exactly one output transaction with the
// truncated mean, minimum and maximum of both fields over the filled slots, the
// fill count, and the frame rate ticks_per_second*256/mean_interframe in Q16.8,
// saturated to 24 bits (zero for an empty window or a zero mean). The block
// takes one transaction at a time: it walks the ring memory through its single
// read port, then runs three divisions of 40 steps each on one shared radix-2
// divider (two means, then the rate), then loads the output register once it is
// free; a clear, or a window whose mean interframe is zero, finishes sooner.
// ticks_per_second is written on the cfg channel; the user must write it only
// while the block is idle, and the block itself does not enforce this.
module frame_time_window_stats (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ftws_pkg::in_t               in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ftws_pkg::out_t              out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ftws_pkg::TICK_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_DIV_END,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_IF,
        PH_BUSY,
        PH_RATE
    } phase_t;

    localparam int MEM_W = 2 * ftws_pkg::TICK_W;

    state_t                          state_reg, state_next;
    phase_t                          phase_reg, phase_next;
    logic [ftws_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic [ftws_pkg::FILL_W-1:0]     fill_reg, fill_next;
    logic [ftws_pkg::TICK_W-1:0]     tps_reg, tps_next;
    logic [ftws_pkg::FILL_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                            pend_reg, pend_next;
    logic                            first_reg, first_next;
    logic [ftws_pkg::SUM_W-1:0]      if_sum_reg, if_sum_next;
    logic [ftws_pkg::SUM_W-1:0]      bz_sum_reg, bz_sum_next;
    logic [ftws_pkg::TICK_W-1:0]     if_min_reg, if_min_next;
    logic [ftws_pkg::TICK_W-1:0]     if_max_reg, if_max_next;
    logic [ftws_pkg::TICK_W-1:0]     bz_min_reg, bz_min_next;
    logic [ftws_pkg::TICK_W-1:0]     bz_max_reg, bz_max_next;
    logic [ftws_pkg::TICK_W-1:0]     if_avg_reg, if_avg_next;
    logic [ftws_pkg::TICK_W-1:0]     bz_avg_reg, bz_avg_next;
    logic [ftws_pkg::RATE_W-1:0]     rate_reg, rate_next;
    logic [ftws_pkg::DIV_W-1:0]      quo_reg, quo_next;
    logic [ftws_pkg::TICK_W-1:0]     rem_reg, rem_next;
    logic [ftws_pkg::TICK_W-1:0]     dvs_reg, dvs_next;
    logic [ftws_pkg::STEP_W-1:0]     step_reg, step_next;
    logic                            out_valid_reg, out_valid_next;
    ftws_pkg::out_t                  out_data_reg, out_data_next;

    // Ring memory: {interframe, busy} per slot
    logic [MEM_W-1:0]                mem [ftws_pkg::WINDOW_DEPTH];
    logic [MEM_W-1:0]                mem_q;
    logic                            mem_we;
    logic                            mem_re;
    logic [ftws_pkg::SLOT_W-1:0]     mem_raddr;

    // Shared divider datapath
    logic [ftws_pkg::TICK_W:0]       rem_shift;
    logic                            rem_ge;

    logic [ftws_pkg::TICK_W-1:0]     v_if;
    logic [ftws_pkg::TICK_W-1:0]     v_bz;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign v_if = mem_q[MEM_W-1:ftws_pkg::TICK_W];
    assign v_bz = mem_q[ftws_pkg::TICK_W-1:0];

    // One restoring division step
    assign rem_shift = {rem_reg, quo_reg[ftws_pkg::DIV_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, dvs_reg});

    // Write ring on add, read one slot per cycle during the scan
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot_reg] <= {in_data.interframe_ticks, in_data.frame_ticks};
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        tps_next       = tps_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        first_next     = first_reg;
        if_sum_next    = if_sum_reg;
        bz_sum_next    = bz_sum_reg;
        if_min_next    = if_min_reg;
        if_max_next    = if_max_reg;
        bz_min_next    = bz_min_reg;
        bz_max_next    = bz_max_reg;
        if_avg_next    = if_avg_reg;
        bz_avg_next    = bz_avg_reg;
        rate_next      = rate_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = rd_idx_reg[ftws_pkg::SLOT_W-1:0];

        // Take the configuration write
        if (cfg_valid)
        begin
            tps_next = cfg_data;
        end

        // Drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.opcode == ftws_pkg::OP_CLEAR)
                    begin
                        slot_next = '0;
                        fill_next = '0;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (slot_reg == ftws_pkg::SLOT_W'(ftws_pkg::WINDOW_DEPTH - 1))
                        begin
                            slot_next = '0;
                        end
                        else
                        begin
                            slot_next = slot_reg + 1'b1;
                        end
                        if (fill_reg < ftws_pkg::FILL_W'(ftws_pkg::WINDOW_DEPTH))
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    first_next  = 1'b1;
                    if_sum_next = '0;
                    bz_sum_next = '0;
                    if_min_next = '0;
                    if_max_next = '0;
                    bz_min_next = '0;
                    bz_max_next = '0;
                    if_avg_next = '0;
                    bz_avg_next = '0;
                    rate_next   = '0;
                    state_next  = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue the next slot read
                if (rd_idx_reg < fill_reg)
                begin
                    mem_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // Fold in the slot read last cycle
                if (pend_reg)
                begin
                    if_sum_next = if_sum_reg + ftws_pkg::SUM_W'(v_if);
                    bz_sum_next = bz_sum_reg + ftws_pkg::SUM_W'(v_bz);
                    first_next  = 1'b0;
                    if (first_reg || v_if < if_min_reg)
                    begin
                        if_min_next = v_if;
                    end
                    if (first_reg || v_if > if_max_reg)
                    begin
                        if_max_next = v_if;
                    end
                    if (first_reg || v_bz < bz_min_reg)
                    begin
                        bz_min_next = v_bz;
                    end
                    if (first_reg || v_bz > bz_max_reg)
                    begin
                        bz_max_next = v_bz;
                    end
                end

                if (!(rd_idx_reg < fill_reg) && !pend_reg)
                begin
                    if (fill_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        phase_next = PH_IF;
                        state_next = ST_DIV_LOAD;
                    end
                end
            end

            ST_DIV_LOAD:
            begin
                rem_next  = '0;
                step_next = ftws_pkg::STEP_W'(ftws_pkg::DIV_W);
                unique case (phase_reg)
                    PH_IF:
                    begin
                        quo_next = ftws_pkg::DIV_W'(if_sum_reg);
                        dvs_next = ftws_pkg::TICK_W'(fill_reg);
                    end
                    PH_BUSY:
                    begin
                        quo_next = ftws_pkg::DIV_W'(bz_sum_reg);
                        dvs_next = ftws_pkg::TICK_W'(fill_reg);
                    end
                    PH_RATE:
                    begin
                        quo_next = ftws_pkg::DIV_W'({tps_reg, {ftws_pkg::FRAC_W{1'b0}}});
                        dvs_next = if_avg_reg;
                    end
                    default:
                    begin
                        quo_next = '0;
                        dvs_next = '0;
                    end
                endcase
                state_next = ST_DIV_STEP;
            end

            ST_DIV_STEP:
            begin
                // Shift in one dividend bit, subtract when it fits
                if (rem_ge)
                begin
                    rem_next = ftws_pkg::TICK_W'(rem_shift - {1'b0, dvs_reg});
                end
                else
                begin
                    rem_next = rem_shift[ftws_pkg::TICK_W-1:0];
                end
                quo_next  = {quo_reg[ftws_pkg::DIV_W-2:0], rem_ge};
                step_next = step_reg - 1'b1;
                if (step_reg == ftws_pkg::STEP_W'(1))
                begin
                    state_next = ST_DIV_END;
                end
            end

            ST_DIV_END:
            begin
                unique case (phase_reg)
                    PH_IF:
                    begin
                        if_avg_next = quo_reg[ftws_pkg::TICK_W-1:0];
                        phase_next  = PH_BUSY;
                        state_next  = ST_DIV_LOAD;
                    end
                    PH_BUSY:
                    begin
                        bz_avg_next = quo_reg[ftws_pkg::TICK_W-1:0];
                        if (if_avg_reg == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            phase_next = PH_RATE;
                            state_next = ST_DIV_LOAD;
                        end
                    end
                    PH_RATE:
                    begin
                        if (quo_reg > ftws_pkg::DIV_W'(ftws_pkg::RATE_MAX))
                        begin
                            rate_next = ftws_pkg::RATE_MAX;
                        end
                        else
                        begin
                            rate_next = quo_reg[ftws_pkg::RATE_W-1:0];
                        end
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.interframe_avg = if_avg_reg;
                    out_data_next.interframe_min = if_min_reg;
                    out_data_next.interframe_max = if_max_reg;
                    out_data_next.busy_avg       = bz_avg_reg;
                    out_data_next.busy_min       = bz_min_reg;
                    out_data_next.busy_max       = bz_max_reg;
                    out_data_next.rate_q8        = rate_reg;
                    out_data_next.filled         = ftws_pkg::FILLED_W'(fill_reg);
                    out_valid_next               = 1'b1;
                    state_next                   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IF;
            slot_reg      <= '0;
            fill_reg      <= '0;
            tps_reg       <= ftws_pkg::TPS_RESET;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            first_reg     <= 1'b1;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            tps_reg       <= tps_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            first_reg     <= first_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if_sum_reg   <= if_sum_next;
        bz_sum_reg   <= bz_sum_next;
        if_min_reg   <= if_min_next;
        if_max_reg   <= if_max_next;
        bz_min_reg   <= bz_min_next;
        bz_max_reg   <= bz_max_next;
        if_avg_reg   <= if_avg_next;
        bz_avg_reg   <= bz_avg_next;
        rate_reg     <= rate_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== hdl/ftws_checker.sv =====
module ftws_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input ftws_pkg::out_t              out_data
);

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    // Fill count never exceeds the window
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.filled <= ftws_pkg::FILLED_W'(ftws_pkg::WINDOW_DEPTH))
        else $error("filled exceeds window depth");

    // Empty window reports all zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.filled == '0 |->
            out_data.interframe_avg == '0 && out_data.interframe_min == '0 &&
            out_data.interframe_max == '0 && out_data.busy_avg == '0 &&
            out_data.busy_min == '0 && out_data.busy_max == '0 &&
            out_data.rate_q8 == '0)
        else $error("nonzero statistics for empty window");

    // Mean lies between the extremes
    a_avg_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            out_data.interframe_min <= out_data.interframe_avg &&
            out_data.interframe_avg <= out_data.interframe_max &&
            out_data.busy_min <= out_data.busy_avg &&
            out_data.busy_avg <= out_data.busy_max)
        else $error("mean outside min/max");

    // Zero mean interframe gives zero rate
    a_zero_rate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.interframe_avg == '0 |-> out_data.rate_q8 == '0)
        else $error("nonzero rate for zero mean interframe");

endmodule

bind frame_time_window_stats ftws_checker u_ftws_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== verif/tb_top.sv =====
module tb_top;

    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 600;
    localparam int DRAIN_WAIT  = 300;

    // Class of tick values drawn for one stretch of frames
    typedef enum int
    {
        TICKS_ANY,
        TICKS_TINY,
        TICKS_VIDEO,
        TICKS_EDGE,
        TICKS_RATE_KNEE
    } tick_class_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    ftws_pkg::in_t                 in_data   = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    ftws_pkg::out_t                out_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [ftws_pkg::TICK_W-1:0]   cfg_data  = '0;

    // Frames waiting to be offered and window results waiting to arrive
    ftws_pkg::in_t                 frame_q[$];
    ftws_pkg::out_t                pending_stats[$];
    int                            frames_queued = 0;
    int                            frames_taken  = 0;
    int                            stats_seen    = 0;
    int                            fail_count    = 0;
    logic                          in_taken      = 1'b0;

    // Mirror of the window held by the block
    logic [ftws_pkg::TICK_W-1:0]   spacing_hist [ftws_pkg::WINDOW_DEPTH];
    logic [ftws_pkg::TICK_W-1:0]   busy_hist    [ftws_pkg::WINDOW_DEPTH];
    int                            next_slot    = 0;
    int                            held_count   = 0;
    logic [ftws_pkg::TICK_W-1:0]   tick_rate    = ftws_pkg::TPS_RESET;

    // Sender and receiver pacing
    int                            burst_left   = 0;
    int                            gap_left     = 0;
    int                            rx_mode      = 0;
    int                            mode_left    = 0;
    int                            hold_left    = 0;
    int                            long_hold_at = 300;
    int                            rx_tick      = 0;
    int                            stall_cycles = 0;

    frame_time_window_stats u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Apply one frame to the mirrored window and return the statistics it yields
    function automatic ftws_pkg::out_t window_update(input ftws_pkg::in_t item);
        ftws_pkg::out_t r;
        logic [63:0]    gap_sum;
        logic [63:0]    busy_sum;
        logic [63:0]    rate;
        logic [31:0]    gmin;
        logic [31:0]    gmax;
        logic [31:0]    bmin;
        logic [31:0]    bmax;
        if (item.opcode == ftws_pkg::OP_CLEAR)
        begin
            next_slot  = 0;
            held_count = 0;
        end
        else
        begin
            spacing_hist[next_slot] = item.interframe_ticks;
            busy_hist[next_slot]    = item.frame_ticks;
            next_slot = (next_slot == ftws_pkg::WINDOW_DEPTH - 1) ? 0 : next_slot + 1;
            if (held_count < ftws_pkg::WINDOW_DEPTH)
                held_count++;
        end
        r = '0;
        if (held_count != 0)
        begin
            gap_sum  = '0;
            busy_sum = '0;
            gmin = spacing_hist[0];
            gmax = spacing_hist[0];
            bmin = busy_hist[0];
            bmax = busy_hist[0];
            for (int k = 0; k < held_count; k++)
            begin
                gap_sum  += 64'(spacing_hist[k]);
                busy_sum += 64'(busy_hist[k]);
                if (spacing_hist[k] < gmin) gmin = spacing_hist[k];
                if (spacing_hist[k] > gmax) gmax = spacing_hist[k];
                if (busy_hist[k] < bmin) bmin = busy_hist[k];
                if (busy_hist[k] > bmax) bmax = busy_hist[k];
            end
            r.interframe_avg = ftws_pkg::TICK_W'(gap_sum / 64'(held_count));
            r.interframe_min = gmin;
            r.interframe_max = gmax;
            r.busy_avg       = ftws_pkg::TICK_W'(busy_sum / 64'(held_count));
            r.busy_min       = bmin;
            r.busy_max       = bmax;
            if (r.interframe_avg != 0)
            begin
                rate = {24'b0, tick_rate, 8'b0} / 64'(r.interframe_avg);
                r.rate_q8 = (rate > 64'(ftws_pkg::RATE_MAX)) ?
                            ftws_pkg::RATE_MAX : rate[ftws_pkg::RATE_W-1:0];
            end
        end
        r.filled = ftws_pkg::FILLED_W'(held_count);
        return r;
    endfunction

    function automatic int field_off(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    function automatic logic [ftws_pkg::TICK_W-1:0] pick_ticks(input tick_class_t cls);
        case (cls)
            TICKS_TINY:      return $urandom_range(0, 255);
            TICKS_VIDEO:     return $urandom_range(8_000_000, 40_000_000);
            TICKS_RATE_KNEE: return $urandom_range(14_000, 17_000);
            TICKS_EDGE:
            begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return 32'hFFFF_FFFF;
                    2:       return 32'hFFFF_FFFE;
                    default: return 32'd1;
                endcase
            end
            default:         return $urandom;
        endcase
    endfunction

    task automatic queue_frame(input logic op, input logic [ftws_pkg::TICK_W-1:0] gap,
                               input logic [ftws_pkg::TICK_W-1:0] busy);
        ftws_pkg::in_t item;
        item.opcode           = op;
        item.interframe_ticks = gap;
        item.frame_ticks      = busy;
        frame_q.push_back(item);
        frames_queued++;
    endtask

    // Mostly runs of samples that fill and wrap the window, with rare clears
    task automatic queue_random_frames(input int count);
        tick_class_t gap_cls;
        tick_class_t busy_cls;
        int          seg_left;
        seg_left = 0;
        gap_cls  = TICKS_ANY;
        busy_cls = TICKS_ANY;
        for (int n = 0; n < count; n++)
        begin
            if (seg_left == 0)
            begin
                gap_cls  = tick_class_t'($urandom_range(0, 4));
                busy_cls = tick_class_t'($urandom_range(0, 4));
                seg_left = $urandom_range(5, 60);
            end
            seg_left--;
            if ($urandom_range(0, 199) == 0)
                repeat ($urandom_range(2, 4))
                    queue_frame(ftws_pkg::OP_CLEAR, $urandom, $urandom);
            else if ($urandom_range(0, 99) < 2)
                queue_frame(ftws_pkg::OP_CLEAR, $urandom, $urandom);
            else
                queue_frame(ftws_pkg::OP_ADD, pick_ticks(gap_cls), pick_ticks(busy_cls));
        end
    endtask

    // Wait for the window to go idle, then load a new tick rate
    task automatic write_tick_rate(input logic [ftws_pkg::TICK_W-1:0] value);
        while (frames_taken != frames_queued || pending_stats.size() != 0)
            @(negedge clk);
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tick_rate = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Offer frames in bursts; hold the transaction until it is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (frame_q.size() > 0)
            begin
                in_data  <= frame_q.pop_front();
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 30);
                    case ($urandom_range(0, 7))
                        0, 1:    gap_left = 0;
                        2:       gap_left = $urandom_range(21, 250);
                        default: gap_left = $urandom_range(1, 20);
                    endcase
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Predict the result of every accepted frame
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            pending_stats.push_back(window_update(in_data));
            frames_taken++;
        end
    end

    // Stall the result channel: random modes, plus a long hold now and then
    always @(negedge clk)
    begin
        rx_tick++;
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stats_seen >= long_hold_at)
        begin
            hold_left    = LONG_HOLD;
            long_hold_at = long_hold_at + 700;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            case (rx_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (rx_tick[1:0] != 2'b00);
            endcase
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        ftws_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            stats_seen++;
            if (pending_stats.size() == 0)
            begin
                $error("result transaction with no frame pending");
                fail_count++;
            end
            else
            begin
                want = pending_stats.pop_front();
                fail_count += field_off("interframe_avg", want.interframe_avg,
                                        out_data.interframe_avg)
                            + field_off("interframe_min", want.interframe_min,
                                        out_data.interframe_min)
                            + field_off("interframe_max", want.interframe_max,
                                        out_data.interframe_max)
                            + field_off("busy_avg", want.busy_avg, out_data.busy_avg)
                            + field_off("busy_min", want.busy_min, out_data.busy_min)
                            + field_off("busy_max", want.busy_max, out_data.busy_max)
                            + field_off("rate_q8", 32'(want.rate_q8), 32'(out_data.rate_q8))
                            + field_off("filled", 32'(want.filled), 32'(out_data.filled));
            end
        end
    end

    // Abort when no channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("frame_time_window_stats: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Empty window, zero mean, sums past 32 bits, clears, rate knee
        queue_frame(ftws_pkg::OP_CLEAR, 32'd0, 32'd0);
        queue_frame(ftws_pkg::OP_ADD, 32'd0, 32'd0);
        queue_frame(ftws_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_frame(ftws_pkg::OP_ADD, 32'hFFFF_FFFF, 32'd0);
        queue_frame(ftws_pkg::OP_ADD, 32'd1, 32'hFFFF_FFFF);
        queue_frame(ftws_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_frame(ftws_pkg::OP_ADD, 32'd1, 32'd1);
        queue_frame(ftws_pkg::OP_ADD, 32'hAAAA_AAAA, 32'h5555_5555);
        queue_frame(ftws_pkg::OP_ADD, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_frame(ftws_pkg::OP_CLEAR, 32'h1234_5678, 32'h8765_4321);
        queue_frame(ftws_pkg::OP_CLEAR, 32'd0, 32'd0);
        queue_frame(ftws_pkg::OP_ADD, 32'd15_258, 32'd7_000);
        queue_frame(ftws_pkg::OP_CLEAR, 32'd0, 32'd0);
        queue_frame(ftws_pkg::OP_ADD, 32'd15_259, 32'd7_000);
        queue_frame(ftws_pkg::OP_ADD, 32'd15_259, 32'd7_001);
        queue_frame(ftws_pkg::OP_CLEAR, 32'd0, 32'd0);
        queue_frame(ftws_pkg::OP_ADD, 32'd16_666_667, 32'd8_000_000);
        queue_frame(ftws_pkg::OP_ADD, 32'd16_666_666, 32'd12_000_000);
        queue_frame(ftws_pkg::OP_ADD, 32'd33_333_333, 32'd30_000_000);
        queue_frame(ftws_pkg::OP_ADD, 32'hFFFF_FFFF, 32'd0);
        queue_frame(ftws_pkg::OP_ADD, 32'd0, 32'hFFFF_FFFF);
        queue_random_frames(180);

        // Sweep the tick rate across its extremes and a few typical values
        write_tick_rate(32'd1);
        queue_random_frames(200);
        write_tick_rate(32'hFFFF_FFFF);
        queue_random_frames(200);
        write_tick_rate(32'd0);
        queue_random_frames(200);
        write_tick_rate($urandom);
        queue_random_frames(200);
        write_tick_rate(32'd90_000);
        queue_random_frames(200);
        write_tick_rate($urandom);
        queue_random_frames(200);

        while (frames_taken != frames_queued || pending_stats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (fail_count == 0)
            $display("frame_time_window_stats: match");
        else
            $display("frame_time_window_stats: mismatch");
        $finish;
    end

endmodule
